/* hdl/ecng_pkg.sv */
// Package for the envelope compressor with noise gate.
// Holds the default sample width, register reset values, arithmetic constants,
// the register index codes and the sequencer states. Depends on nothing.
package ecng_pkg;

	// Default sample width and fixed point format of the gains.
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int Q_BITS          = 16;
	localparam int GATE_W          = Q_BITS + 1;

	// Arithmetic constants of the gain law.
	localparam int RATE_FULL   = 256;
	localparam int COMP_TARGET = 30000;
	localparam int PERCENT     = 100;

	// Configuration registers: 9 bits each.
	localparam int REG_W          = 9;
	localparam int SUSTAIN_RESET  = 256;
	localparam int RATE_RESET     = 40;
	localparam int THRESH_RESET   = 256;

	// Register index codes (word address on the configuration port).
	typedef enum logic [1:0] {
		REG_SUSTAIN = 2'd0,
		REG_RATE    = 2'd1,
		REG_THRESH  = 2'd2
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENV1,
		ST_ENV2,
		ST_PREP1,
		ST_PREP2,
		ST_DIVC,
		ST_SETG,
		ST_DIVG,
		ST_SETM,
		ST_MULG,
		ST_SETX,
		ST_MULX,
		ST_DONE
	} state_t;

endpackage

/* hdl/envelope_compressor_noise_gate.sv */
// Envelope follower compressor with noise gate, top level.
// One shared add/subtract unit does the long divisions and multiplications under a
// small sequencer. Depends on ecng_pkg.
//
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       s_tdata: sample_in
// m_*       out        m_tvalid / m_tready       m_tdata: sample_out
// APB       in/out     psel, penable, pready=1   regs at 0x0, 0x4, 0x8
//
// The shared add/subtract unit works one bit per cycle through the compression
// division (41 bits at SAMPLE_BITS = 16), the gate division (32 bits there, only
// when the gate is closed) and the two gain multiplies. The block takes no new
// item until the current one has reached the last state.
// Reset clears the envelope and all control state and sets the registers to their reset values.
// A waiting result does not block the next item; only the last state holds until it is taken.
module envelope_compressor_noise_gate #(
	parameter int SAMPLE_BITS = ecng_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: sample_in [SAMPLE_BITS-1:0], zero padding above
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
	// Output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: sample_out [SAMPLE_BITS-1:0], zero padding above
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,
	// Configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [3:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int SB     = SAMPLE_BITS;
	localparam int DATA_W = ((SB + 7) / 8) * 8;
	localparam int QB     = ecng_pkg::Q_BITS;
	localparam int GW     = ecng_pkg::GATE_W;
	localparam int RW     = ecng_pkg::REG_W;
	// Magnitude width of the compression numerator before the Q shift.
	localparam int MW     = (SB + 9 > 25) ? SB + 9 : 25;
	// Width of the shared work register (dividend/quotient or multiplier).
	localparam int WW     = MW + QB;
	localparam int MULW   = (SB > GW) ? SB : GW;
	// Accumulator width: remainder or partial product.
	localparam int AW     = WW + MULW + 1;
	localparam int CW     = $clog2(WW + 1);
	localparam int PW     = SB + 10;
	localparam int TW     = 16;
	localparam int GCW    = (SB > TW) ? SB : TW;
	localparam int YW     = AW - QB;
	localparam logic [YW-1:0] Y_MAX     = YW'((1 << (SB - 1)) - 1);
	localparam logic [YW-1:0] Y_MIN_MAG = YW'(1 << (SB - 1));
	localparam logic [SB-1:0] ENV_MAX   = SB'(1 << (SB - 1));

	ecng_pkg::state_t state_q, state_d;

	logic [CW-1:0]        cnt_q, cnt_d;
	logic                 out_valid_q, out_valid_d;
	logic [SB-1:0]        env_q, env_d;
	logic [RW-1:0]        sustain_q, rate_q, thresh_q;

	logic [SB-1:0]        x_q, x_d;
	logic [SB-1:0]        a_q, a_d;
	logic [SB+8:0]        p_q, p_d;
	logic signed [PW-1:0] t1_q, t1_d;
	logic [WW-1:0]        w_q, w_d;
	logic [AW-1:0]        acc_q, acc_d;
	logic [WW-1:0]        opb_q, opb_d;
	logic [WW-1:0]        comp_q, comp_d;
	logic                 comp_neg_q, comp_neg_d;
	logic [SB-1:0]        out_q, out_d;

	// Shared add/subtract unit.
	logic                 div_mode;
	logic                 step_bit;
	logic [AW-1:0]        alu_a, alu_b, alu_sum;

	// Per-state helper values.
	logic [RW-1:0]        rate_n, rate_w;
	logic [SB+9:0]        env_sum;
	logic [SB-1:0]        env_e;
	logic signed [9:0]    sus_diff;
	logic signed [MW:0]   m_val;
	logic [MW:0]          m_mag;
	logic [MW-1:0]        s30;
	logic [TW-1:0]        t100;
	logic                 gate_open;
	logic [YW-1:0]        y_mag;
	logic                 y_neg;
	logic [SB-1:0]        y_sat;

	// The shared unit: one step of a shift-subtract division or a shift-add
	// multiply, both most significant bit first.
	always_comb begin
		div_mode = (state_q == ecng_pkg::ST_DIVC) || (state_q == ecng_pkg::ST_DIVG);
		step_bit = div_mode ? w_q[WW-1] : 1'b0;
		alu_a    = {acc_q[AW-2:0], step_bit};
		alu_b    = {{(AW-WW){1'b0}}, opb_q};
		alu_sum  = alu_a + (div_mode ? ~alu_b : alu_b) + {{(AW-1){1'b0}}, div_mode};
	end

	// Helpers for the envelope, the numerator, the gate test and saturation.
	always_comb begin
		rate_n    = (rate_q > RW'(ecng_pkg::RATE_FULL)) ? RW'(ecng_pkg::RATE_FULL) : rate_q;
		rate_w    = RW'(ecng_pkg::RATE_FULL) - rate_n;
		env_sum   = {1'b0, p_q} + ({{(SB+1){1'b0}}, rate_n} * {10'b0, a_q});
		env_e     = (env_q == '0) ? SB'(1) : env_q;
		sus_diff  = 10'(ecng_pkg::PERCENT) - {1'b0, sustain_q};
		s30       = {{(MW-RW){1'b0}}, sustain_q} * MW'(ecng_pkg::COMP_TARGET);
		m_val     = $signed({{(MW+1-PW){t1_q[PW-1]}}, t1_q}) + $signed({1'b0, s30});
		m_mag     = m_val[MW] ? (~m_val + 1'b1) : m_val;
		t100      = {{(TW-RW){1'b0}}, thresh_q} * TW'(ecng_pkg::PERCENT);
		gate_open = (thresh_q <= RW'(1)) ||
			({{(GCW-SB){1'b0}}, env_q} > {{(GCW-TW){1'b0}}, t100});
		y_mag     = acc_q[AW-1:QB];
		y_neg     = comp_neg_q ^ x_q[SB-1];
		if (y_neg) begin
			y_sat = (y_mag > Y_MIN_MAG) ? {1'b1, {(SB-1){1'b0}}} : (~y_mag[SB-1:0] + 1'b1);
		end else begin
			y_sat = (y_mag > Y_MAX) ? {1'b0, {(SB-1){1'b1}}} : y_mag[SB-1:0];
		end
	end

	// Sequencer: next state and datapath updates.
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q;
		env_d       = env_q;
		x_d         = x_q;
		a_d         = a_q;
		p_d         = p_q;
		t1_d        = t1_q;
		w_d         = w_q;
		acc_d       = acc_q;
		opb_d       = opb_q;
		comp_d      = comp_q;
		comp_neg_d  = comp_neg_q;
		out_d       = out_q;

		if (out_valid_q && m_tready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			ecng_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					x_d     = s_tdata[SB-1:0];
					state_d = ecng_pkg::ST_ENV1;
				end
			end
			ecng_pkg::ST_ENV1: begin
				a_d     = x_q[SB-1] ? (~x_q + 1'b1) : x_q;
				p_d     = {{SB{1'b0}}, rate_w} * {9'b0, env_q};
				state_d = ecng_pkg::ST_ENV2;
			end
			ecng_pkg::ST_ENV2: begin
				env_d   = env_sum[SB+7:8];
				state_d = ecng_pkg::ST_PREP1;
			end
			ecng_pkg::ST_PREP1: begin
				t1_d    = $signed({{(PW-10){sus_diff[9]}}, sus_diff}) *
					$signed({{(PW-SB){1'b0}}, env_e});
				opb_d   = {{(WW-SB){1'b0}}, env_e} * WW'(ecng_pkg::PERCENT);
				state_d = ecng_pkg::ST_PREP2;
			end
			ecng_pkg::ST_PREP2: begin
				comp_neg_d = m_val[MW];
				w_d        = {m_mag[MW-1:0], {QB{1'b0}}};
				acc_d      = '0;
				cnt_d      = CW'(WW);
				state_d    = ecng_pkg::ST_DIVC;
			end
			ecng_pkg::ST_DIVC, ecng_pkg::ST_DIVG: begin
				acc_d = alu_sum[AW-1] ? alu_a : alu_sum;
				w_d   = {w_q[WW-2:0], ~alu_sum[AW-1]};
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					state_d = (state_q == ecng_pkg::ST_DIVC) ? ecng_pkg::ST_SETG
						: ecng_pkg::ST_SETM;
				end
			end
			ecng_pkg::ST_SETG: begin
				// The compression gain magnitude is now in the work register.
				comp_d = w_q;
				acc_d  = '0;
				if (gate_open) begin
					w_d     = {GW'(1 << QB), {(WW-GW){1'b0}}};
					opb_d   = w_q;
					cnt_d   = CW'(GW);
					state_d = ecng_pkg::ST_MULG;
				end else begin
					w_d     = {env_q, {(WW-SB){1'b0}}};
					opb_d   = {{(WW-TW){1'b0}}, t100};
					cnt_d   = CW'(SB + QB);
					state_d = ecng_pkg::ST_DIVG;
				end
			end
			ecng_pkg::ST_SETM: begin
				w_d     = {w_q[GW-1:0], {(WW-GW){1'b0}}};
				opb_d   = comp_q;
				acc_d   = '0;
				cnt_d   = CW'(GW);
				state_d = ecng_pkg::ST_MULG;
			end
			ecng_pkg::ST_MULG, ecng_pkg::ST_MULX: begin
				acc_d = w_q[WW-1] ? alu_sum : alu_a;
				w_d   = {w_q[WW-2:0], 1'b0};
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					state_d = (state_q == ecng_pkg::ST_MULG) ? ecng_pkg::ST_SETX
						: ecng_pkg::ST_DONE;
				end
			end
			ecng_pkg::ST_SETX: begin
				// Combined gain is the product shifted back to Q16.
				opb_d   = acc_q[WW+QB-1:QB];
				w_d     = {a_q, {(WW-SB){1'b0}}};
				acc_d   = '0;
				cnt_d   = CW'(SB);
				state_d = ecng_pkg::ST_MULX;
			end
			ecng_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_d       = y_sat;
					out_valid_d = 1'b1;
					state_d     = ecng_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ecng_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state, envelope and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ecng_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			env_q       <= '0;
			sustain_q   <= RW'(ecng_pkg::SUSTAIN_RESET);
			rate_q      <= RW'(ecng_pkg::RATE_RESET);
			thresh_q    <= RW'(ecng_pkg::THRESH_RESET);
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
			env_q       <= env_d;
			if (psel && penable && pwrite) begin
				unique case (ecng_pkg::reg_idx_t'(paddr[3:2]))
					ecng_pkg::REG_SUSTAIN: sustain_q <= pwdata[RW-1:0];
					ecng_pkg::REG_RATE:    rate_q    <= pwdata[RW-1:0];
					ecng_pkg::REG_THRESH:  thresh_q  <= pwdata[RW-1:0];
					default: ;
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		x_q        <= x_d;
		a_q        <= a_d;
		p_q        <= p_d;
		t1_q       <= t1_d;
		w_q        <= w_d;
		acc_q      <= acc_d;
		opb_q      <= opb_d;
		comp_q     <= comp_d;
		comp_neg_q <= comp_neg_d;
		out_q      <= out_d;
	end

	// Register read back.
	always_comb begin
		unique case (ecng_pkg::reg_idx_t'(paddr[3:2]))
			ecng_pkg::REG_SUSTAIN: prdata = {{(32-RW){1'b0}}, sustain_q};
			ecng_pkg::REG_RATE:    prdata = {{(32-RW){1'b0}}, rate_q};
			ecng_pkg::REG_THRESH:  prdata = {{(32-RW){1'b0}}, thresh_q};
			default:               prdata = '0;
		endcase
	end

	assign pready   = 1'b1;
	assign s_tready = (state_q == ecng_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(DATA_W-SB){1'b0}}, out_q};

	// An accepted item keeps the block busy for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// The iterating states always have steps left to run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ecng_pkg::ST_DIVC || state_q == ecng_pkg::ST_DIVG ||
		 state_q == ecng_pkg::ST_MULG || state_q == ecng_pkg::ST_MULX) |-> cnt_q != '0)
		else $error("shared unit running with an empty step count");

	// The envelope never exceeds the largest sample magnitude.
	assert property (@(posedge clk) disable iff (!arst_n) env_q <= ENV_MAX)
		else $error("envelope out of range");

endmodule
